// File: hw/rtl/tfgw_pkg.sv
// Package for the text framebuffer glyph writer.
// Holds geometry constants, command codes and the 5x7 font table.
package tfgw_pkg;

    localparam int SCREEN_WIDTH = 128;
    localparam int PAGE_COUNT   = 8;
    localparam int COL_W        = $clog2(SCREEN_WIDTH);
    localparam int PAGE_W       = $clog2(PAGE_COUNT);
    localparam int ADDR_W       = COL_W + PAGE_W;
    localparam int ROW_COUNT    = PAGE_COUNT * 8;

    // Configuration register index on the APB port
    localparam logic [0:0] REG_DISPLAY_ENABLED = 1'b0;

    typedef enum logic [2:0] {
        OP_GLYPH = 3'd0,
        OP_LARGE = 3'd1,
        OP_LINE  = 3'd2,
        OP_CLEAR = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    localparam logic [7:0] CODE_FIRST = 8'd32;
    localparam logic [7:0] CODE_LAST  = 8'd126;
    localparam logic [7:0] GAP_BYTE   = 8'h00;

    typedef logic [39:0] glyph_t;

    // Font columns packed column 0 in bits 7:0
    function automatic glyph_t font_glyph(input logic [7:0] code);
        logic [6:0] idx;
        glyph_t g;
        idx = (code < CODE_FIRST || code > CODE_LAST) ? 7'd0 : 7'(code - CODE_FIRST);
        case (idx)
            7'd0: g = {8'h00,8'h00,8'h00,8'h00,8'h00};
            7'd1: g = {8'h00,8'h00,8'h5F,8'h00,8'h00};
            7'd2: g = {8'h00,8'h07,8'h00,8'h07,8'h00};
            7'd3: g = {8'h14,8'h7F,8'h14,8'h7F,8'h14};
            7'd4: g = {8'h12,8'h2A,8'h7F,8'h2A,8'h24};
            7'd5: g = {8'h62,8'h64,8'h08,8'h13,8'h23};
            7'd6: g = {8'h50,8'h22,8'h55,8'h49,8'h36};
            7'd7: g = {8'h00,8'h00,8'h03,8'h05,8'h00};
            7'd8: g = {8'h00,8'h41,8'h22,8'h1C,8'h00};
            7'd9: g = {8'h00,8'h1C,8'h22,8'h41,8'h00};
            7'd10: g = {8'h14,8'h08,8'h3E,8'h08,8'h14};
            7'd11: g = {8'h08,8'h08,8'h3E,8'h08,8'h08};
            7'd12: g = {8'h00,8'h00,8'h30,8'h50,8'h00};
            7'd13: g = {8'h08,8'h08,8'h08,8'h08,8'h08};
            7'd14: g = {8'h00,8'h00,8'h60,8'h60,8'h00};
            7'd15: g = {8'h02,8'h04,8'h08,8'h10,8'h20};
            7'd16: g = {8'h3E,8'h45,8'h49,8'h51,8'h3E};
            7'd17: g = {8'h00,8'h40,8'h7F,8'h42,8'h00};
            7'd18: g = {8'h46,8'h49,8'h51,8'h61,8'h42};
            7'd19: g = {8'h31,8'h4B,8'h45,8'h41,8'h21};
            7'd20: g = {8'h10,8'h7F,8'h12,8'h14,8'h18};
            7'd21: g = {8'h39,8'h45,8'h45,8'h45,8'h27};
            7'd22: g = {8'h30,8'h49,8'h49,8'h4A,8'h3C};
            7'd23: g = {8'h03,8'h05,8'h09,8'h71,8'h01};
            7'd24: g = {8'h36,8'h49,8'h49,8'h49,8'h36};
            7'd25: g = {8'h1E,8'h29,8'h49,8'h49,8'h06};
            7'd26: g = {8'h00,8'h00,8'h36,8'h36,8'h00};
            7'd27: g = {8'h00,8'h00,8'h36,8'h56,8'h00};
            7'd28: g = {8'h00,8'h41,8'h22,8'h14,8'h08};
            7'd29: g = {8'h14,8'h14,8'h14,8'h14,8'h14};
            7'd30: g = {8'h08,8'h14,8'h22,8'h41,8'h00};
            7'd31: g = {8'h06,8'h09,8'h51,8'h01,8'h02};
            7'd32: g = {8'h3E,8'h41,8'h79,8'h49,8'h32};
            7'd33: g = {8'h7E,8'h11,8'h11,8'h11,8'h7E};
            7'd34: g = {8'h36,8'h49,8'h49,8'h49,8'h7F};
            7'd35: g = {8'h22,8'h41,8'h41,8'h41,8'h3E};
            7'd36: g = {8'h1C,8'h22,8'h41,8'h41,8'h7F};
            7'd37: g = {8'h41,8'h49,8'h49,8'h49,8'h7F};
            7'd38: g = {8'h01,8'h09,8'h09,8'h09,8'h7F};
            7'd39: g = {8'h7A,8'h49,8'h49,8'h41,8'h3E};
            7'd40: g = {8'h7F,8'h08,8'h08,8'h08,8'h7F};
            7'd41: g = {8'h00,8'h41,8'h7F,8'h41,8'h00};
            7'd42: g = {8'h01,8'h3F,8'h41,8'h40,8'h20};
            7'd43: g = {8'h41,8'h22,8'h14,8'h08,8'h7F};
            7'd44: g = {8'h40,8'h40,8'h40,8'h40,8'h7F};
            7'd45: g = {8'h7F,8'h02,8'h04,8'h02,8'h7F};
            7'd46: g = {8'h7F,8'h10,8'h08,8'h04,8'h7F};
            7'd47: g = {8'h3E,8'h41,8'h41,8'h41,8'h3E};
            7'd48: g = {8'h06,8'h09,8'h09,8'h09,8'h7F};
            7'd49: g = {8'h5E,8'h21,8'h51,8'h41,8'h3E};
            7'd50: g = {8'h46,8'h29,8'h19,8'h09,8'h7F};
            7'd51: g = {8'h31,8'h49,8'h49,8'h49,8'h46};
            7'd52: g = {8'h01,8'h01,8'h7F,8'h01,8'h01};
            7'd53: g = {8'h3F,8'h40,8'h40,8'h40,8'h3F};
            7'd54: g = {8'h1F,8'h20,8'h40,8'h20,8'h1F};
            7'd55: g = {8'h3F,8'h40,8'h38,8'h40,8'h3F};
            7'd56: g = {8'h63,8'h14,8'h08,8'h14,8'h63};
            7'd57: g = {8'h07,8'h08,8'h70,8'h08,8'h07};
            7'd58: g = {8'h43,8'h45,8'h49,8'h51,8'h61};
            7'd59: g = {8'h00,8'h41,8'h41,8'h7F,8'h00};
            7'd60: g = {8'h20,8'h10,8'h08,8'h04,8'h02};
            7'd61: g = {8'h00,8'h7F,8'h41,8'h41,8'h00};
            7'd62: g = {8'h04,8'h02,8'h01,8'h02,8'h04};
            7'd63: g = {8'h40,8'h40,8'h40,8'h40,8'h40};
            7'd64: g = {8'h00,8'h04,8'h02,8'h01,8'h00};
            7'd65: g = {8'h78,8'h54,8'h54,8'h54,8'h20};
            7'd66: g = {8'h38,8'h44,8'h44,8'h48,8'h7F};
            7'd67: g = {8'h20,8'h44,8'h44,8'h44,8'h38};
            7'd68: g = {8'h7F,8'h48,8'h44,8'h44,8'h38};
            7'd69: g = {8'h18,8'h54,8'h54,8'h54,8'h38};
            7'd70: g = {8'h02,8'h01,8'h09,8'h7E,8'h08};
            7'd71: g = {8'h3E,8'h52,8'h52,8'h52,8'h0C};
            7'd72: g = {8'h78,8'h04,8'h04,8'h08,8'h7F};
            7'd73: g = {8'h00,8'h40,8'h7D,8'h44,8'h00};
            7'd74: g = {8'h00,8'h3D,8'h44,8'h40,8'h20};
            7'd75: g = {8'h00,8'h44,8'h28,8'h10,8'h7F};
            7'd76: g = {8'h00,8'h40,8'h7F,8'h41,8'h00};
            7'd77: g = {8'h78,8'h04,8'h18,8'h04,8'h7C};
            7'd78: g = {8'h78,8'h04,8'h04,8'h08,8'h7C};
            7'd79: g = {8'h38,8'h44,8'h44,8'h44,8'h38};
            7'd80: g = {8'h08,8'h14,8'h14,8'h14,8'h7C};
            7'd81: g = {8'h7C,8'h18,8'h14,8'h14,8'h08};
            7'd82: g = {8'h08,8'h04,8'h04,8'h08,8'h7C};
            7'd83: g = {8'h20,8'h54,8'h54,8'h54,8'h48};
            7'd84: g = {8'h20,8'h40,8'h44,8'h3F,8'h04};
            7'd85: g = {8'h7C,8'h20,8'h40,8'h40,8'h3C};
            7'd86: g = {8'h1C,8'h20,8'h40,8'h20,8'h1C};
            7'd87: g = {8'h3C,8'h40,8'h30,8'h40,8'h3C};
            7'd88: g = {8'h44,8'h28,8'h10,8'h28,8'h44};
            7'd89: g = {8'h3C,8'h50,8'h50,8'h50,8'h0C};
            7'd90: g = {8'h44,8'h4C,8'h54,8'h64,8'h44};
            7'd91: g = {8'h00,8'h41,8'h36,8'h08,8'h00};
            7'd92: g = {8'h00,8'h00,8'h7F,8'h00,8'h00};
            7'd93: g = {8'h00,8'h08,8'h36,8'h41,8'h00};
            7'd94: g = {8'h08,8'h10,8'h08,8'h08,8'h10};
            default: g = '0;
        endcase
        return g;
    endfunction

    // Double each of four bits into two adjacent bits
    function automatic logic [7:0] widen_nibble(input logic [3:0] nib);
        return {nib[3], nib[3], nib[2], nib[2], nib[1], nib[1], nib[0], nib[0]};
    endfunction

endpackage

// File: hw/rtl/tfgw_if.sv
// Valid/ready channel interfaces for the glyph writer.
// Depends on tfgw_pkg.
interface tfgw_cmd_if
    import tfgw_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] column;
    logic [3:0] page_index;
    logic [7:0] char_code;
    logic [6:0] line_row;

    modport source (output valid, op, column, page_index, char_code, line_row, input ready);
    modport sink   (input valid, op, column, page_index, char_code, line_row, output ready);
endinterface

interface tfgw_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       accepted;

    modport source (output valid, read_data, accepted, input ready);
    modport sink   (input valid, read_data, accepted, output ready);
endinterface

// File: hw/rtl/tfgw_store.sv
// Framebuffer memory: one write port, one registered read port.
// Depends on tfgw_pkg.
module tfgw_store
    import tfgw_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);
    logic [7:0] mem [SCREEN_WIDTH*PAGE_COUNT];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hw/rtl/text_framebuffer_glyph_writer_core.sv
// Text framebuffer glyph writer: top level.
// Depends on tfgw_pkg, tfgw_if and tfgw_store.
//
// Usage:
// - cmd carries one command per transaction (glyph, large glyph, line,
//   clear, read); rsp returns exactly one result transaction per command.
// - The APB port holds display_enabled at address 0.
// - Commands run one at a time on a single-port-per-direction memory, one
//   memory access per cycle. Glyph: up to 6 writes; large glyph: 24 writes;
//   line: read-modify-write pipelined over SCREEN_WIDTH columns; clear:
//   SCREEN_WIDTH*PAGE_COUNT writes; read: one memory read. Rejected
//   commands skip the memory; every result then passes the result register.
// - After reset a clearing pass writes all SCREEN_WIDTH*PAGE_COUNT (1024)
//   bytes with zero; cmd.ready stays low meanwhile.
// - The result sits in an output register; cmd is taken again once that
//   register is empty or being drained, so a stalled rsp holds the block.
module text_framebuffer_glyph_writer_core
    import tfgw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    tfgw_cmd_if.sink    cmd,
    tfgw_rsp_if.source  rsp
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_WRITE, S_LINE, S_READ, S_DONE
    } state_t;

    localparam int CNT_W = ADDR_W + 1;

    state_t             state_reg;
    logic               enabled_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   limit_reg;
    logic               large_reg;
    logic [COL_W:0]     col_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [39:0]        glyph_reg;
    logic [7:0]         mask_reg;
    logic               rsp_valid_reg;
    logic [7:0]         rsp_data_reg;
    logic               rsp_ok_reg;
    // line pipeline: address of the read in flight
    logic               lv_reg;
    logic [ADDR_W-1:0]  laddr_reg;

    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [7:0]         wdata;
    logic [ADDR_W-1:0]  raddr;
    logic [7:0]         rdata;
    logic               take;
    logic               rsp_free;

    tfgw_store u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    assign pready = 1'b1;
    assign prdata = {31'd0, enabled_reg};
    assign rsp_free = !rsp_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE) && rsp_free;
    assign take = cmd.valid && cmd.ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.read_data = rsp_data_reg;
    assign rsp.accepted = rsp_ok_reg;

    // Byte, column and page for the current write step
    logic [7:0]        step_byte;
    logic [COL_W:0]    step_col;
    logic [PAGE_W-1:0] step_page;
    logic              step_in;
    logic [2:0]        gi;
    logic [7:0]        gcol;
    always_comb
    begin
        gi = '0;
        gcol = '0;
        step_byte = GAP_BYTE;
        step_col = col_reg;
        step_page = page_reg;
        if (large_reg)
        begin
            // two pages per column step: even count upper page
            gi = 3'(cnt_reg[4:2]);
            step_col = col_reg + (COL_W+1)'(cnt_reg[4:1]);
            step_page = page_reg + PAGE_W'(cnt_reg[0]);
            if (cnt_reg[4:1] < 4'd10)
            begin
                gcol = glyph_reg[8*gi +: 8];
                step_byte = cnt_reg[0] ? widen_nibble(gcol[7:4]) : widen_nibble(gcol[3:0]);
            end
        end
        else
        begin
            gi = 3'(cnt_reg[2:0]);
            step_col = col_reg + (COL_W+1)'(cnt_reg[2:0]);
            if (cnt_reg[2:0] < 3'd5)
            begin
                step_byte = glyph_reg[8*gi +: 8];
            end
        end
        step_in = step_col < (COL_W+1)'(SCREEN_WIDTH);
    end

    // Memory port drive
    always_comb
    begin
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = {page_reg, col_reg[COL_W-1:0]};
        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                waddr = cnt_reg[ADDR_W-1:0];
            end
            S_WRITE:
            begin
                we = step_in;
                waddr = {step_page, step_col[COL_W-1:0]};
                wdata = step_byte;
            end
            S_LINE:
            begin
                raddr = {page_reg, cnt_reg[COL_W-1:0]};
                we = lv_reg;
                waddr = laddr_reg;
                wdata = rdata | mask_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Command sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            enabled_reg <= 1'b0;
            cnt_reg <= '0;
            limit_reg <= '0;
            rsp_valid_reg <= 1'b0;
            lv_reg <= 1'b0;
            large_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == REG_DISPLAY_ENABLED)
            begin
                enabled_reg <= pwdata[0];
            end
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg[ADDR_W-1:0] == ADDR_W'(SCREEN_WIDTH*PAGE_COUNT-1))
                    begin
                        cnt_reg <= '0;
                        state_reg <= limit_reg[0] ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (take)
                    begin
                        cnt_reg <= '0;
                        col_reg <= {1'b0, cmd.column[COL_W-1:0]};
                        page_reg <= cmd.page_index[PAGE_W-1:0];
                        glyph_reg <= font_glyph(cmd.char_code);
                        rsp_data_reg <= '0;
                        rsp_ok_reg <= 1'b0;
                        large_reg <= 1'b0;
                        state_reg <= S_DONE;
                        if (cmd.op == OP_CLEAR)
                        begin
                            rsp_ok_reg <= 1'b1;
                            limit_reg <= CNT_W'(1);
                            state_reg <= S_CLEAR;
                        end
                        else if (enabled_reg && cmd.op == OP_GLYPH)
                        begin
                            if (32'(cmd.page_index) < PAGE_COUNT)
                            begin
                                rsp_ok_reg <= 1'b1;
                                limit_reg <= CNT_W'(5);
                                if (32'(cmd.column) < SCREEN_WIDTH)
                                begin
                                    state_reg <= S_WRITE;
                                end
                            end
                        end
                        else if (enabled_reg && cmd.op == OP_LARGE)
                        begin
                            if (32'(cmd.column) + 12 <= SCREEN_WIDTH
                                && 32'(cmd.page_index) + 1 < PAGE_COUNT)
                            begin
                                rsp_ok_reg <= 1'b1;
                                large_reg <= 1'b1;
                                limit_reg <= CNT_W'(23);
                                state_reg <= S_WRITE;
                            end
                        end
                        else if (enabled_reg && cmd.op == OP_LINE)
                        begin
                            if (32'(cmd.line_row) < ROW_COUNT)
                            begin
                                rsp_ok_reg <= 1'b1;
                                page_reg <= cmd.line_row[PAGE_W+2:3];
                                mask_reg <= 8'(1) << cmd.line_row[2:0];
                                state_reg <= S_LINE;
                            end
                        end
                        else if (enabled_reg && cmd.op == OP_READ)
                        begin
                            if (32'(cmd.page_index) < PAGE_COUNT
                                && 32'(cmd.column) < SCREEN_WIDTH)
                            begin
                                rsp_ok_reg <= 1'b1;
                                state_reg <= S_READ;
                            end
                        end
                    end
                end
                S_WRITE:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == limit_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_LINE:
                begin
                    lv_reg <= cnt_reg < CNT_W'(SCREEN_WIDTH);
                    laddr_reg <= {page_reg, cnt_reg[COL_W-1:0]};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(SCREEN_WIDTH))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_READ:
                begin
                    // memory data arrives in the cycle after the address
                    if (cnt_reg[0])
                    begin
                        rsp_data_reg <= rdata;
                        state_reg <= S_DONE;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_DONE:
                begin
                    // deliver the result once the output register frees
                    lv_reg <= 1'b0;
                    limit_reg <= '0;
                    cnt_reg <= '0;
                    if (rsp_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
